// ===== hdl/lac_pkg.sv =====
// ----------------------------------------------------------------------------
// lac_pkg: shared constants, types and helpers for the LFU admission cache
// Sizes of the counter table and the way file, outcome codes, saturating add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lac_pkg;

    localparam int CACHE_WAYS   = 8;
    localparam int NUM_ROUTINES = 64;
    localparam int COUNT_WIDTH  = 32;

    localparam int ID_W   = 6;
    localparam int WAY_W  = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
    localparam int FILL_W = $clog2(CACHE_WAYS + 1);
    localparam int SLOT_W = (NUM_ROUTINES > 1) ? $clog2(NUM_ROUTINES) : 1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OC_HIT     = 2'd0,
        OC_FILL    = 2'd1,
        OC_REPLACE = 2'd2,
        OC_REJECT  = 2'd3
    } outcome_t;

    // increment that sticks at all ones
    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

endpackage

// ===== hdl/lfu_admission_cache.sv =====
// ----------------------------------------------------------------------------
// lfu_admission_cache: LFU admission cache for routine ids
// A request reads its counter, bumps it, walks the filled ways for a hit or
// a fill, and on a full miss walks every way for the LFU victim and decides.
// One request at a time; the next input transfer can be taken in the cycle
// after the result is loaded, and the time per item is set by the way walk.
// Reset (rst_n, async, active low) clears every routine counter and empties
// the cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_admission_cache
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [lac_pkg::ID_W-1:0] routine_id,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    use_fast_path,
    output logic [1:0]              outcome,
    output logic [2:0]              way_index
);

    import lac_pkg::*;

    // Sequencer. Each request:
    //   IDLE   - take the transfer, read the routine's counter from the table
    //   CNT    - saturating increment of the global count, write it back
    //   SCAN   - walk filled ways one a cycle looking for the id; on reaching
    //            the fill count either fill the next free way or start MIN
    //   MIN    - walk all ways one a cycle, keeping the first smallest count
    //   DECIDE - replace the LFU way if its count is not above the newcomer's
    //   DONE   - wait for the output register, then load the result
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CNT    = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_MIN    = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Counter table: a memory with a registered read port. Its reset value
    // is supplied by per-entry valid bits, so no clearing pass is needed.
    count_t                  cnt_mem [NUM_ROUTINES];
    logic [NUM_ROUTINES-1:0] cnt_vld_reg;
    count_t                  cnt_rd_reg;
    logic                    cnt_rd_vld_reg;

    // Way file: no reset, only filled ways are ever read.
    logic [ID_W-1:0] way_id_reg    [CACHE_WAYS];
    count_t          way_count_reg [CACHE_WAYS];
    logic [FILL_W-1:0] filled_reg, filled_next;

    // Per-request working registers
    logic [ID_W-1:0]   id_reg;
    count_t            global_reg;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [WAY_W-1:0]  min_way_reg, min_way_next;
    count_t            min_cnt_reg, min_cnt_next;
    logic              wk_hit_reg, wk_hit_next;
    outcome_t          wk_outcome_reg, wk_outcome_next;
    logic [WAY_W-1:0]  wk_way_reg, wk_way_next;

    // Output register
    logic              out_valid_reg;
    logic              res_hit_reg;
    outcome_t          res_outcome_reg;
    logic [WAY_W-1:0]  res_way_reg;

    logic              in_xfer;
    logic              out_free;
    logic              res_load;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] cur_slot;
    logic [WAY_W-1:0]  cur_way;
    logic [WAY_W-1:0]  fill_way;
    count_t            global_new;
    logic              scan_end;
    logic              scan_match;
    logic              min_last;
    logic              do_hit_wr;
    logic              do_fill_wr;
    logic              do_repl_wr;

    // Ids are below NUM_ROUTINES (or NUM_ROUTINES is a power of two), so the
    // modulo reduces to a size cast.
    assign in_slot  = SLOT_W'(routine_id);
    assign cur_slot = SLOT_W'(id_reg);
    assign cur_way  = idx_reg[WAY_W-1:0];
    assign fill_way = filled_reg[WAY_W-1:0];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign res_load = (state_reg == ST_DONE) && out_free;

    assign global_new = cnt_rd_vld_reg ? sat_inc(cnt_rd_reg) : COUNT_WIDTH'(1);
    assign scan_end   = (idx_reg == filled_reg);
    assign scan_match = (way_id_reg[cur_way] == id_reg);
    assign min_last   = (idx_reg == FILL_W'(CACHE_WAYS - 1));

    assign do_hit_wr  = (state_reg == ST_SCAN) && !scan_end && scan_match;
    assign do_fill_wr = (state_reg == ST_SCAN) && scan_end
                        && (filled_reg != FILL_W'(CACHE_WAYS));
    assign do_repl_wr = (state_reg == ST_DECIDE) && (min_cnt_reg <= global_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        filled_next     = filled_reg;
        min_way_next    = min_way_reg;
        min_cnt_next    = min_cnt_reg;
        wk_hit_next     = wk_hit_reg;
        wk_outcome_next = wk_outcome_reg;
        wk_way_next     = wk_way_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT:
            begin
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (filled_reg != FILL_W'(CACHE_WAYS))
                    begin
                        filled_next     = filled_reg + FILL_W'(1);
                        wk_hit_next     = 1'b1;
                        wk_outcome_next = OC_FILL;
                        wk_way_next     = fill_way;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        // start at the maximum so way 0 is taken even at that count; a tie goes to the lowest way
                        idx_next     = '0;
                        min_way_next = '0;
                        min_cnt_next = COUNT_MAX;
                        state_next   = ST_MIN;
                    end
                end
                else if (scan_match)
                begin
                    wk_hit_next     = 1'b1;
                    wk_outcome_next = OC_HIT;
                    wk_way_next     = cur_way;
                    state_next      = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + FILL_W'(1);
                end
            end
            ST_MIN:
            begin
                if (way_count_reg[cur_way] < min_cnt_reg)
                begin
                    min_way_next = cur_way;
                    min_cnt_next = way_count_reg[cur_way];
                end
                if (min_last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + FILL_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (min_cnt_reg <= global_reg)
                begin
                    wk_hit_next     = 1'b1;
                    wk_outcome_next = OC_REPLACE;
                    wk_way_next     = min_way_reg;
                end
                else
                begin
                    wk_hit_next     = 1'b0;
                    wk_outcome_next = OC_REJECT;
                    wk_way_next     = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            if (state_reg == ST_CNT)
            begin
                cnt_vld_reg[cur_slot] <= 1'b1;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Counter table port: read on the input transfer, write back in CNT
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cnt_rd_reg <= cnt_mem[in_slot];
        end
        if (state_reg == ST_CNT)
        begin
            cnt_mem[cur_slot] <= global_new;
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            id_reg         <= routine_id;
            cnt_rd_vld_reg <= cnt_vld_reg[in_slot];
        end
        if (state_reg == ST_CNT)
        begin
            global_reg <= global_new;
        end
        idx_reg        <= idx_next;
        min_way_reg    <= min_way_next;
        min_cnt_reg    <= min_cnt_next;
        wk_hit_reg     <= wk_hit_next;
        wk_outcome_reg <= wk_outcome_next;
        wk_way_reg     <= wk_way_next;
        if (res_load)
        begin
            res_hit_reg     <= wk_hit_reg;
            res_outcome_reg <= wk_outcome_reg;
            res_way_reg     <= wk_way_reg;
        end
    end

    // Way file: one write per request at most
    always_ff @(posedge clk)
    begin
        if (do_hit_wr)
        begin
            way_count_reg[cur_way] <= sat_inc(way_count_reg[cur_way]);
        end
        if (do_fill_wr)
        begin
            way_id_reg[fill_way]    <= id_reg;
            way_count_reg[fill_way] <= global_reg;
        end
        if (do_repl_wr)
        begin
            way_id_reg[min_way_reg]    <= id_reg;
            way_count_reg[min_way_reg] <= global_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign use_fast_path = res_hit_reg;
    assign outcome       = res_outcome_reg;
    assign way_index     = 3'(res_way_reg);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_W'(CACHE_WAYS))
        else $error("fill count beyond the number of ways");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg != $past(filled_reg)) |->
            (filled_reg == $past(filled_reg) + FILL_W'(1)))
        else $error("fill count moved by other than one");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == OC_REJECT) |-> (!use_fast_path && way_index == 3'd0))
        else $error("rejected result with fast path or way set");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finish step");
`endif

endmodule

// ===== bench/tb_lfu_admission_cache.sv =====
// ----------------------------------------------------------------------------
// tb_lfu_admission_cache: self-checking bench for the LFU admission cache
// Directed and random routine ids are driven through the request channel.
// A local copy of the counter table and way file predicts each result, and
// every result transfer is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lfu_admission_cache;

    import lac_pkg::*;

    // result as the block should report it
    typedef struct packed {
        logic           fast;
        outcome_t       oc;
        logic [2:0]     way;
    } admit_result_t;

    localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES = 60;     // more than a full-miss walk
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 322;
    localparam int HOT_IDS     = 12;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [ID_W-1:0]    routine_id    = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic               use_fast_path;
    logic [1:0]         outcome;
    logic [2:0]         way_index;

    // shadow of the block state
    count_t             call_count [NUM_ROUTINES];
    logic [ID_W-1:0]    cached_id  [CACHE_WAYS];
    count_t             cached_cnt [CACHE_WAYS];
    int                 cached_n;

    logic [ID_W-1:0]    requests[$];          // ids still to be driven
    admit_result_t      admit_results[$];     // predictions awaiting a result transfer
    int                 taken_n      = 0;     // request transfers so far
    int                 quiet_cycles = 0;
    int                 errors       = 0;
    logic               calm;

    always #6 clk = ~clk;

    lfu_admission_cache dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .routine_id    (routine_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .use_fast_path (use_fast_path),
        .outcome       (outcome),
        .way_index     (way_index)
    );

    // stretch of the run with no idling on either side
    assign calm = (taken_n >= 900) && (taken_n < 1200);

    function automatic count_t bump(input count_t v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // append one id to the pending requests
    function automatic void add_request(input logic [ID_W-1:0] id);
        requests = {requests, id};
    endfunction

    // one request through the shadow state: counter, lookup, fill or LFU victim
    function automatic admit_result_t admit_request(input logic [ID_W-1:0] id);
        admit_result_t r;
        count_t        global_n;
        int            slot;
        int            victim;
        slot             = int'(id) % NUM_ROUTINES;
        call_count[slot] = bump(call_count[slot]);
        global_n         = call_count[slot];
        for (int w = 0; w < cached_n; w++)
        begin
            if (cached_id[w] == id)
            begin
                cached_cnt[w] = bump(cached_cnt[w]);
                r.fast = 1'b1;
                r.oc   = OC_HIT;
                r.way  = 3'(w);
                return r;
            end
        end
        if (cached_n < CACHE_WAYS)
        begin
            cached_id[cached_n]  = id;
            cached_cnt[cached_n] = global_n;
            r.fast   = 1'b1;
            r.oc     = OC_FILL;
            r.way    = 3'(cached_n);
            cached_n = cached_n + 1;
            return r;
        end
        // strict less-than keeps the lowest way on a tie
        victim = 0;
        for (int w = 1; w < CACHE_WAYS; w++)
        begin
            if (cached_cnt[w] < cached_cnt[victim])
                victim = w;
        end
        if (cached_cnt[victim] <= global_n)
        begin
            cached_id[victim]  = id;
            cached_cnt[victim] = global_n;
            r.fast = 1'b1;
            r.oc   = OC_REPLACE;
            r.way  = 3'(victim);
        end
        else
        begin
            r.fast = 1'b0;
            r.oc   = OC_REJECT;
            r.way  = 3'd0;
        end
        return r;
    endfunction

    // request driver: predicts on each transfer, holds the payload while stalled
    always @(posedge clk)
    begin
        admit_result_t pred;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pred          = admit_request(routine_id);
                admit_results = {admit_results, pred};
                taken_n <= taken_n + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (requests.size() != 0 && (calm || $urandom_range(0, 99) >= 11))
                begin
                    in_valid   <= 1'b1;
                    routine_id <= requests.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each result transfer, stalls at random outside the calm stretch
    always @(posedge clk)
    begin
        admit_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (admit_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = admit_results.pop_front();
                    if (use_fast_path !== want.fast)
                    begin
                        $error("use_fast_path: expected %0d, actual %0d",
                               want.fast, use_fast_path);
                        errors++;
                    end
                    if (outcome !== want.oc)
                    begin
                        $error("outcome: expected %s, actual %0d", want.oc.name(), outcome);
                        errors++;
                    end
                    if (way_index !== want.way)
                    begin
                        $error("way_index: expected %0d, actual %0d", want.way, way_index);
                        errors++;
                    end
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 11);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // wait until every queued request has gone in and every result come out
    task automatic drain;
        while (requests.size() != 0 || in_valid || admit_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [ID_W-1:0] hot [HOT_IDS];
        int              pick;

        foreach (call_count[i])
            call_count[i] = '0;
        foreach (cached_id[i])
        begin
            cached_id[i]  = '0;
            cached_cnt[i] = '0;
        end
        cached_n = 0;

        // directed: fill ways 0..7 with ids 0..7, hit each once, so every
        // way holds a count of two
        for (int i = 0; i < 8; i++)
            add_request(ID_W'(i));
        for (int i = 0; i < 8; i++)
            add_request(ID_W'(i));
        add_request(ID_W'(63));   // newcomer count 1 below all ways: rejected
        add_request(ID_W'(63));   // count 2 ties every way: lowest way replaced
        add_request(ID_W'(0));    // evicted id comes back over way 0
        add_request(ID_W'(7));    // hit in the top way
        add_request(ID_W'(63));   // replaces the next least used way

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // let the directed transfers finish before anything else is sent
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            // a working set a little larger than the cache keeps it churning;
            // the remainder is cold ids that mostly get rejected
            foreach (hot[i])
                hot[i] = ID_W'($urandom_range(0, 63));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    add_request(hot[$urandom_range(0, HOT_IDS - 1)]);
                else if (pick < 80)
                    add_request(pick[0] ? ID_W'(63) : ID_W'(0));
                else
                    add_request(ID_W'($urandom_range(0, 63)));
            end
            // sender holds back once mid-run until the block has emptied
            if (p == 2)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && admit_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lac_pkg.sv
hdl/lfu_admission_cache.sv
bench/tb_lfu_admission_cache.sv
